FILE: design/fdbp_pkg.sv
// Shared types and constants for the 4D block partition walker.
// Holds flag and result codes, sibling selectors, register indexes and the
// result item struct. No dependencies.
package fdbp_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF  = 10;

    localparam int FLAG_W    = 2;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 9;
    localparam int LEN_W     = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;

    // split flag codes
    localparam logic [FLAG_W-1:0] FLAG_LEAF    = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_INTRA   = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_INTER   = 2'd2;
    localparam logic [FLAG_W-1:0] FLAG_UNKNOWN = 2'd3;

    // result kind codes
    localparam logic [KIND_W-1:0] KIND_LEAF  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SPLIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVF   = 2'd3;

    // child selector; for a pending frame it is also the count of siblings left
    localparam logic [1:0] SEL_LO_LO = 2'd0;
    localparam logic [1:0] SEL_HI_LO = 2'd1;
    localparam logic [1:0] SEL_HI_HI = 2'd2;
    localparam logic [1:0] SEL_LO_HI = 2'd3;

    // axis indexes
    localparam logic [1:0] AX_T = 2'd0;
    localparam logic [1:0] AX_S = 2'd1;
    localparam logic [1:0] AX_V = 2'd2;
    localparam logic [1:0] AX_U = 2'd3;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_T = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_S = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_V = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_U = 2'd3;

    localparam logic [CFG_W-1:0] ROOT_T_RST = 10'd16;
    localparam logic [CFG_W-1:0] ROOT_S_RST = 10'd16;
    localparam logic [CFG_W-1:0] ROOT_V_RST = 10'd64;
    localparam logic [CFG_W-1:0] ROOT_U_RST = 10'd64;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos_t;
        logic [POS_W-1:0]  pos_s;
        logic [POS_W-1:0]  pos_v;
        logic [POS_W-1:0]  pos_u;
        logic [LEN_W-1:0]  len_t;
        logic [LEN_W-1:0]  len_s;
        logic [LEN_W-1:0]  len_v;
        logic [LEN_W-1:0]  len_u;
        logic              partition_done;
    } t_result;

endpackage

FILE: design/four_d_block_partition_walker.sv
// Four-dimensional block partition walker (top level).
// Depends on fdbp_pkg, fdbp_split and fdbp_stack.
//
// Usage: each input item carries one decoded split flag. The block walks a
// depth-first split tree over a (t,s,v,u) block whose root lengths come from
// the four root size registers, and returns exactly one result item per flag:
// leaf, split, drop or stack overflow, with the node the flag applied to and
// a done bit at the end of each partition. The next flag after done starts a
// new root.
// Throughput: one flag per cycle while o_ready is high. Pending siblings are
// kept as one parent frame per split (three siblings derived on pop); the top
// frame sits in registers and the frames below it in a single-port-write
// memory whose registered read always prefetches the next frame down.
// Stalls: results go to an output register backed by a one-entry skid, so a
// flag is still taken while one result waits; o_ready drops only once the
// skid is full. Configuration writes take effect at once; write only while
// the block is idle.
// Reset (synchronous, active low): root sizes return to 16/16/64/64, the
// walk and the pending stack are empty, no result is valid.
module four_d_block_partition_walker #(
    parameter int STACK_DEPTH = fdbp_pkg::STACK_DEPTH_DEF,
    parameter int COORD_BITS  = fdbp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fdbp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fdbp_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fdbp_pkg::FLAG_W-1:0]     i_split_flag,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [fdbp_pkg::KIND_W-1:0]     o_kind,
    output logic [fdbp_pkg::POS_W-1:0]      o_pos_t,
    output logic [fdbp_pkg::POS_W-1:0]      o_pos_s,
    output logic [fdbp_pkg::POS_W-1:0]      o_pos_v,
    output logic [fdbp_pkg::POS_W-1:0]      o_pos_u,
    output logic [fdbp_pkg::LEN_W-1:0]      o_len_t,
    output logic [fdbp_pkg::LEN_W-1:0]      o_len_s,
    output logic [fdbp_pkg::LEN_W-1:0]      o_len_v,
    output logic [fdbp_pkg::LEN_W-1:0]      o_len_u,
    output logic                            o_partition_done
);
    import fdbp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int FW  = 8 * CB + 3;

    // configuration
    logic [CFG_W-1:0] r_root_t, r_root_s, r_root_v, r_root_u;

    // walk state
    logic                 r_active, n_active;
    logic [CW-1:0]        r_pcnt, n_pcnt;
    logic [CW-1:0]        r_mcnt, n_mcnt;
    logic [3:0][CB-1:0]   r_cur_pos, n_cur_pos;
    logic [3:0][CB-1:0]   r_cur_len, n_cur_len;
    logic [3:0][CB-1:0]   r_top_pos, n_top_pos;
    logic [3:0][CB-1:0]   r_top_len, n_top_len;
    logic                 r_top_inter, n_top_inter;
    logic [1:0]           r_top_rem, n_top_rem;

    // output register and skid
    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;
    t_result res;

    logic               acc;
    logic               out_fire;
    logic               is_split;
    logic               is_inter;
    logic               ovf;
    logic [3:0][CB-1:0] cur_pos, cur_len;
    logic [3:0][CB-1:0] lolo_pos, lolo_len;
    logic [3:0][CB-1:0] sib_pos, sib_len;
    logic [FW-1:0]      below;
    logic [FW-1:0]      wr_frame;
    logic               wr_en;
    logic [CW-1:0]      mcnt_m1;
    logic [AW-1:0]      rd_addr;
    logic [KIND_W-1:0]  kind;
    logic               done;
    logic [3:0][31:0]   pos_w, len_w;

    assign acc      = i_valid && o_ready;
    assign out_fire = r_out_vld && i_ready;
    assign o_ready  = !r_skid_vld;
    assign is_split = (i_split_flag == FLAG_INTRA) || (i_split_flag == FLAG_INTER);
    assign is_inter = (i_split_flag == FLAG_INTER);
    assign ovf      = (32'(r_pcnt) + 32'd3) > 32'(STACK_DEPTH);

    // a fresh partition starts at the origin with the configured lengths
    always_comb begin
        if (r_active) begin
            cur_pos = r_cur_pos;
            cur_len = r_cur_len;
        end else begin
            cur_pos = '0;
            cur_len[AX_T] = CB'(r_root_t);
            cur_len[AX_S] = CB'(r_root_s);
            cur_len[AX_V] = CB'(r_root_v);
            cur_len[AX_U] = CB'(r_root_u);
        end
    end

    fdbp_split #(.COORD_BITS(CB)) u_split_lolo (
        .i_pos   (cur_pos),
        .i_len   (cur_len),
        .i_inter (is_inter),
        .i_sel   (SEL_LO_LO),
        .o_pos   (lolo_pos),
        .o_len   (lolo_len)
    );

    fdbp_split #(.COORD_BITS(CB)) u_split_sib (
        .i_pos   (r_top_pos),
        .i_len   (r_top_len),
        .i_inter (r_top_inter),
        .i_sel   (r_top_rem),
        .o_pos   (sib_pos),
        .o_len   (sib_len)
    );

    assign wr_frame = {r_top_inter, r_top_rem, r_top_len, r_top_pos};

    always_comb begin
        n_active    = r_active;
        n_pcnt      = r_pcnt;
        n_mcnt      = r_mcnt;
        n_cur_pos   = r_cur_pos;
        n_cur_len   = r_cur_len;
        n_top_pos   = r_top_pos;
        n_top_len   = r_top_len;
        n_top_inter = r_top_inter;
        n_top_rem   = r_top_rem;
        wr_en       = 1'b0;
        done        = 1'b0;
        kind        = (i_split_flag == FLAG_LEAF) ? KIND_LEAF : KIND_DROP;

        if (is_split) begin
            kind = ovf ? KIND_OVF : KIND_SPLIT;
            done = ovf;
        end else if (r_pcnt == '0) begin
            done = 1'b1;
        end

        if (acc) begin
            n_active = 1'b1;
            if (is_split) begin
                if (ovf) begin
                    // abandon the partition
                    n_active = 1'b0;
                    n_pcnt   = '0;
                    n_mcnt   = '0;
                end else begin
                    n_cur_pos   = lolo_pos;
                    n_cur_len   = lolo_len;
                    n_top_pos   = cur_pos;
                    n_top_len   = cur_len;
                    n_top_inter = is_inter;
                    n_top_rem   = SEL_LO_HI;
                    n_pcnt      = r_pcnt + CW'(3);
                    if (r_pcnt != '0) begin
                        // spill the old top frame
                        wr_en  = 1'b1;
                        n_mcnt = r_mcnt + CW'(1);
                    end
                end
            end else if (r_pcnt != '0) begin
                n_cur_pos = sib_pos;
                n_cur_len = sib_len;
                n_pcnt    = r_pcnt - CW'(1);
                if (r_top_rem != SEL_HI_LO) begin
                    n_top_rem = r_top_rem - 2'd1;
                end else if (r_mcnt != '0) begin
                    // refill the top frame from the prefetched entry
                    n_top_pos   = below[4*CB-1:0];
                    n_top_len   = below[8*CB-1:4*CB];
                    n_top_rem   = below[8*CB+1:8*CB];
                    n_top_inter = below[8*CB+2];
                    n_mcnt      = r_mcnt - CW'(1);
                end
            end else begin
                n_active = 1'b0;
                n_pcnt   = '0;
                n_mcnt   = '0;
            end
        end
    end

    // prefetch the frame just below the next top
    assign mcnt_m1 = n_mcnt - CW'(1);
    assign rd_addr = mcnt_m1[AW-1:0];

    fdbp_stack #(.STACK_DEPTH(STACK_DEPTH), .FRAME_W(FW)) u_stack (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_mcnt[AW-1:0]),
        .i_wr_frame (wr_frame),
        .i_rd_addr  (rd_addr),
        .o_rd_frame (below)
    );

    // result item: node the flag applied to
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pos_w[i] = 32'(cur_pos[i]);
            len_w[i] = 32'(cur_len[i]);
        end
        res.kind           = kind;
        res.pos_t          = pos_w[AX_T][POS_W-1:0];
        res.pos_s          = pos_w[AX_S][POS_W-1:0];
        res.pos_v          = pos_w[AX_V][POS_W-1:0];
        res.pos_u          = pos_w[AX_U][POS_W-1:0];
        res.len_t          = len_w[AX_T][LEN_W-1:0];
        res.len_s          = len_w[AX_S][LEN_W-1:0];
        res.len_v          = len_w[AX_V][LEN_W-1:0];
        res.len_u          = len_w[AX_U][LEN_W-1:0];
        res.partition_done = done;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_t   <= ROOT_T_RST;
            r_root_s   <= ROOT_S_RST;
            r_root_v   <= ROOT_V_RST;
            r_root_u   <= ROOT_U_RST;
            r_active   <= 1'b0;
            r_pcnt     <= '0;
            r_mcnt     <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROOT_T: r_root_t <= i_cfg_data;
                    CFG_ROOT_S: r_root_s <= i_cfg_data;
                    CFG_ROOT_V: r_root_v <= i_cfg_data;
                    CFG_ROOT_U: r_root_u <= i_cfg_data;
                    default:    r_root_t <= r_root_t;
                endcase
            end
            r_active <= n_active;
            r_pcnt   <= n_pcnt;
            r_mcnt   <= n_mcnt;
            if (!r_out_vld || out_fire) begin
                r_out_vld  <= r_skid_vld || acc;
                r_skid_vld <= 1'b0;
            end else if (acc) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_pos   <= n_cur_pos;
        r_cur_len   <= n_cur_len;
        r_top_pos   <= n_top_pos;
        r_top_len   <= n_top_len;
        r_top_inter <= n_top_inter;
        r_top_rem   <= n_top_rem;
        if (!r_out_vld || out_fire) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (acc) begin
            r_skid <= res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_kind           = r_out.kind;
    assign o_pos_t          = r_out.pos_t;
    assign o_pos_s          = r_out.pos_s;
    assign o_pos_v          = r_out.pos_v;
    assign o_pos_u          = r_out.pos_u;
    assign o_len_t          = r_out.len_t;
    assign o_len_s          = r_out.len_s;
    assign o_len_v          = r_out.len_v;
    assign o_len_u          = r_out.len_u;
    assign o_partition_done = r_out.partition_done;

    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pcnt) <= STACK_DEPTH)
        else $error("pending count beyond stack depth");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_pcnt == '0) && (r_mcnt == '0))
        else $error("stack not empty between partitions");

    a_frames_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcnt != '0) |-> (r_mcnt < r_pcnt))
        else $error("more stored frames than pending nodes");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds an item with output register empty");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && done |=> !r_active)
        else $error("walk still active after partition end");

endmodule

FILE: design/fdbp_split.sv
// Child node generator: derives one of the four quarters of a 4D node.
// Splits v/u (intra-view) or t/s (inter-view). Depends on fdbp_pkg.
module fdbp_split #(
    parameter int COORD_BITS = fdbp_pkg::COORD_BITS_DEF
) (
    input  logic [3:0][COORD_BITS-1:0] i_pos,
    input  logic [3:0][COORD_BITS-1:0] i_len,
    input  logic                       i_inter,
    input  logic [1:0]                 i_sel,
    output logic [3:0][COORD_BITS-1:0] o_pos,
    output logic [3:0][COORD_BITS-1:0] o_len
);
    import fdbp_pkg::*;

    logic [1:0]            ax_a;
    logic [1:0]            ax_b;
    logic [COORD_BITS-1:0] half_a;
    logic [COORD_BITS-1:0] half_b;
    logic                  a_hi;
    logic                  b_hi;

    always_comb begin
        ax_a   = i_inter ? AX_T : AX_V;
        ax_b   = i_inter ? AX_S : AX_U;
        half_a = i_len[ax_a] >> 1;
        half_b = i_len[ax_b] >> 1;
        a_hi   = (i_sel == SEL_HI_LO) || (i_sel == SEL_HI_HI);
        b_hi   = (i_sel == SEL_HI_HI) || (i_sel == SEL_LO_HI);

        o_pos = i_pos;
        o_len = i_len;
        o_pos[ax_a] = a_hi ? i_pos[ax_a] + half_a : i_pos[ax_a];
        o_len[ax_a] = a_hi ? i_len[ax_a] - half_a : half_a;
        o_pos[ax_b] = b_hi ? i_pos[ax_b] + half_b : i_pos[ax_b];
        o_len[ax_b] = b_hi ? i_len[ax_b] - half_b : half_b;
    end

endmodule

FILE: design/fdbp_stack.sv
// Pending-frame memory: one write port, one registered read port.
// Forwards write data when the read hits the entry written at the same edge.
// Depends on fdbp_pkg for parameter defaults.
module fdbp_stack #(
    parameter int STACK_DEPTH = fdbp_pkg::STACK_DEPTH_DEF,
    parameter int FRAME_W     = 8 * fdbp_pkg::COORD_BITS_DEF + 3,
    localparam int AW         = $clog2(STACK_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [FRAME_W-1:0] i_wr_frame,
    input  logic [AW-1:0]      i_rd_addr,
    output logic [FRAME_W-1:0] o_rd_frame
);
    import fdbp_pkg::*;

    logic [FRAME_W-1:0] mem [STACK_DEPTH];
    logic [FRAME_W-1:0] r_rd_frame;
    logic [FRAME_W-1:0] r_fwd_frame;
    logic               r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_frame;
        end
        r_rd_frame  <= mem[i_rd_addr];
        r_fwd_frame <= i_wr_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_frame = r_fwd ? r_fwd_frame : r_rd_frame;

endmodule
